@@ rtl/preemptive_priority_line_queue_top_assert.svh @@
`ifndef PREEMPTIVE_PRIORITY_LINE_QUEUE_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_LINE_QUEUE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PPLQ_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define PPLQ_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/pplq_pkg.sv @@
package pplq_pkg;
  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_PUSH    = 3'd1;
  localparam logic [2:0] REQ_PREEMPT = 3'd2;
  localparam logic [2:0] REQ_CLEAR   = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;
  localparam logic [2:0] REQ_FINISH  = 3'd5;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [15:0]        line_id;
    logic [15:0]        text_ref;
    logic signed [15:0] priority_req;
    logic [15:0]        duration;
    logic               interruptible;
    logic [7:0]         line_tag;
    logic [15:0]        tick_amount;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic               speaking;
    logic [15:0]        active_line_id;
    logic [15:0]        active_text_ref;
    logic signed [15:0] active_priority;
    logic               active_interruptible;
    logic [7:0]         active_tag;
    logic               interrupted_flag;
    logic [3:0]         queue_depth;
    logic [15:0]        pushed_total;
    logic [15:0]        served_total;
    logic [15:0]        preempt_total;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        line_id;
    logic signed [15:0] prio;
    logic [15:0]        text_ref;
    logic [15:0]        duration;
    logic               interruptible;
    logic [7:0]         tag;
  } entry_t;
endpackage

@@ rtl/preemptive_priority_line_queue_top.sv @@
// path from acceptance to result word: clear requests and rejected push and finish requests
//   go straight to the done state; tick, preempt and push to an idle line pass the close state
// queued push and remove walk the queue memory one entry a cycle in the scan and shift states
// finish runs the pop pass (pop, then shift while entries remain); tick with expiry does so after close
// one request in flight; the next request is taken only after the result word has been taken
// reset (synchronous, rst_n low): queue empty, idle, counters zero, enable 1, limit 8
module preemptive_priority_line_queue_top import pplq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_data
);
  `include "preemptive_priority_line_queue_top_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;

  localparam logic [1:0] OP_INS = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic rd_en;
  logic we;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  logic [2:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  in_word_t req_r, req_nxt;
  entry_t cur_r, cur_nxt, hold_r, hold_nxt;
  logic busy_r, busy_nxt, pre_r, pre_nxt, acc_r, acc_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt;
  logic [15:0] pushed_r, pushed_nxt, served_r, served_nxt, pre_cnt_r, pre_cnt_nxt;
  logic en_r;
  logic [3:0] lim_r;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  logic [CNT_W-1:0] lim_used;
  logic [16:0] tsum;
  entry_t new_e;

  // head entry captured when a pop pass starts
  entry_t head_q;
  logic head_take_r;

  always_comb begin
    if (lim_r == 4'd0) begin
      lim_used = CNT_W'(1);
    end else if ({28'd0, lim_r} > QUEUE_DEPTH) begin
      lim_used = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim_used = CNT_W'(lim_r);
    end
  end

  assign new_e = '{line_id: req_r.line_id, prio: req_r.priority_req,
                   text_ref: req_r.text_ref, duration: req_r.duration,
                   interruptible: req_r.interruptible, tag: req_r.line_tag};
  assign tsum = {1'b0, timer_r} + {1'b0, req_r.tick_amount};

  assign in_ready  = (st_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = (st_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b1;
      lim_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE: en_r  <= cfg_data[0];
        CFG_LIMIT:  lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; req_nxt = req_r; cur_nxt = cur_r; hold_nxt = hold_r;
    busy_nxt = busy_r; pre_nxt = pre_r; acc_nxt = acc_r; timer_nxt = timer_r;
    cnt_nxt = cnt_r; pos_nxt = pos_r; pushed_nxt = pushed_r; served_nxt = served_r;
    pre_cnt_nxt = pre_cnt_r; out_valid_nxt = out_valid_r; out_nxt = out_r;
    rd_en = 1'b0; rd_addr = pos_r[IDX_W-1:0]; we = 1'b0; wr_addr = pos_r[IDX_W-1:0];
    wr_data = hold_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data;
          acc_nxt = 1'b0;
          st_nxt = ST_DONE;
          unique case (in_data.req_type)
            REQ_TICK: begin
              st_nxt = ST_CLOSE;
            end
            REQ_PUSH: begin
              if (in_data.line_id != 16'd0 && in_data.duration != 16'd0) begin
                acc_nxt = 1'b1;
                pushed_nxt = (pushed_r == 16'hFFFF) ? pushed_r : pushed_r + 16'd1;
                if (busy_r) begin
                  op_nxt = OP_INS;
                  pos_nxt = '0;
                  rd_en = 1'b1;
                  rd_addr = '0;
                  st_nxt = ST_SCAN;
                end else begin
                  st_nxt = ST_CLOSE;
                end
              end
            end
            REQ_PREEMPT: st_nxt = ST_CLOSE;
            REQ_CLEAR: begin
              acc_nxt = 1'b1;
              cnt_nxt = '0;
            end
            REQ_REMOVE: begin
              op_nxt = OP_DEL;
              pos_nxt = '0;
              rd_en = 1'b1;
              rd_addr = '0;
              st_nxt = ST_SCAN;
            end
            REQ_FINISH: begin
              if (busy_r) begin
                acc_nxt = 1'b1;
                st_nxt = ST_POP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLOSE: begin
        st_nxt = ST_DONE;
        if (req_r.req_type == REQ_TICK) begin
          acc_nxt = en_r;
          if (en_r && busy_r) begin
            timer_nxt = tsum[16] ? 16'hFFFF : tsum[15:0];
            if ((tsum[16] ? 16'hFFFF : tsum[15:0]) >= cur_r.duration) begin
              st_nxt = ST_POP;
            end
          end
        end else if (req_r.req_type == REQ_PUSH) begin
          cur_nxt = new_e; busy_nxt = 1'b1; timer_nxt = '0; pre_nxt = 1'b0;
        end else begin
          if (req_r.line_id != 16'd0 && req_r.duration != 16'd0 && busy_r &&
              req_r.priority_req > cur_r.prio && cur_r.interruptible) begin
            acc_nxt = 1'b1; pre_nxt = 1'b1;
            pre_cnt_nxt = (pre_cnt_r == 16'hFFFF) ? pre_cnt_r : pre_cnt_r + 16'd1;
            pushed_nxt = (pushed_r == 16'hFFFF) ? pushed_r : pushed_r + 16'd1;
            cur_nxt = new_e; cur_nxt.interruptible = 1'b1; timer_nxt = '0;
          end
        end
      end
      ST_POP: begin
        served_nxt = (served_r == 16'hFFFF) ? served_r : served_r + 16'd1;
        busy_nxt = 1'b0; timer_nxt = '0; pre_nxt = 1'b0;
        if (cnt_r == '0) begin
          st_nxt = ST_DONE;
        end else begin
          op_nxt = OP_DEL;
          pos_nxt = '0;
          rd_en = 1'b1;
          rd_addr = '0;
          st_nxt = ST_SHIFT;
        end
      end
      ST_SCAN: begin
        if (op_r == OP_INS) begin
          if (pos_r < cnt_r && rd_q.prio >= req_r.priority_req) begin
            pos_nxt = pos_r + CNT_W'(1);
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(1));
          end else if ({1'b0, pos_r} >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            cnt_nxt = (cnt_r > lim_used) ? lim_used : cnt_r;
            st_nxt = ST_DONE;
          end else begin
            hold_nxt = new_e;
            rd_en = 1'b1;
            st_nxt = ST_SHIFT;
          end
        end else begin
          if (pos_r >= cnt_r) begin
            st_nxt = ST_DONE;
          end else if (rd_q.line_id == req_r.line_id) begin
            acc_nxt = 1'b1;
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(1));
            st_nxt = ST_SHIFT;
          end else begin
            pos_nxt = pos_r + CNT_W'(1);
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(1));
          end
        end
      end
      ST_SHIFT: begin
        if (op_r == OP_INS) begin
          we = 1'b1;
          wr_data = hold_r;
          hold_nxt = rd_q;
          if (pos_r >= cnt_r || pos_r == CNT_W'(QUEUE_DEPTH - 1)) begin
            cnt_nxt = (cnt_r < CNT_W'(QUEUE_DEPTH)) ? cnt_r + CNT_W'(1) : cnt_r;
            if (((cnt_r < CNT_W'(QUEUE_DEPTH)) ? cnt_r + CNT_W'(1) : cnt_r) > lim_used) begin
              cnt_nxt = lim_used;
            end
            st_nxt = ST_DONE;
          end else begin
            pos_nxt = pos_r + CNT_W'(1);
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(1));
          end
        end else begin
          if (pos_r + CNT_W'(1) >= cnt_r) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            st_nxt = ST_DONE;
          end else if (head_take_r) begin
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(1));
          end else begin
            we = 1'b1;
            wr_addr = pos_r[IDX_W-1:0];
            wr_data = rd_q;
            pos_nxt = pos_r + CNT_W'(1);
            rd_en = 1'b1;
            rd_addr = IDX_W'(pos_r + CNT_W'(2));
          end
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        st_nxt = ST_IDLE;
        out_nxt = '0;
        out_nxt.accepted = acc_r;
        out_nxt.speaking = busy_r;
        if (busy_r) begin
          out_nxt.active_line_id = cur_r.line_id;
          out_nxt.active_text_ref = cur_r.text_ref;
          out_nxt.active_priority = cur_r.prio;
          out_nxt.active_interruptible = cur_r.interruptible;
          out_nxt.active_tag = cur_r.tag;
          out_nxt.interrupted_flag = pre_r;
        end
        out_nxt.queue_depth = 4'(cnt_r);
        out_nxt.pushed_total = pushed_r;
        out_nxt.served_total = served_r;
        out_nxt.preempt_total = pre_cnt_r;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // pop head: first cycle of a pop pass loads the new active entry
    if (st_r == ST_SHIFT && head_take_r) begin
      cur_nxt = head_q;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_take_r <= 1'b0;
    end else begin
      head_take_r <= (st_r == ST_POP) && (cnt_r != '0);
    end
  end
  assign head_q = rd_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; busy_r <= 1'b0; pre_r <= 1'b0; timer_r <= '0; cnt_r <= '0;
      pushed_r <= '0; served_r <= '0; pre_cnt_r <= '0; out_valid_r <= 1'b0;
      cur_r <= '0; acc_r <= 1'b0;
    end else begin
      st_r <= st_nxt; busy_r <= busy_nxt; pre_r <= pre_nxt;
      timer_r <= timer_nxt; cnt_r <= cnt_nxt; pushed_r <= pushed_nxt;
      served_r <= served_nxt; pre_cnt_r <= pre_cnt_nxt; out_valid_r <= out_valid_nxt;
      cur_r <= cur_nxt; acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; req_r <= req_nxt; hold_r <= hold_nxt; pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

  `PPLQ_ASSERT_IMP(a_depth_max, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `PPLQ_ASSERT_IMP(a_ready_idle, in_ready, st_r == ST_IDLE && !out_valid_r)
  `PPLQ_ASSERT_NXT(a_done_out, st_r == ST_DONE, out_valid_r)
  `PPLQ_ASSERT_IMP(a_pre_busy, pre_r, busy_r)
endmodule
